### hdl/sahc_pkg.sv
// package for the sensor average and hysteresis control block
// item and result types, fixed ratio and duty constants; depends on nothing

package sahc_pkg;

    localparam int SAMPLE_W = 10;
    localparam int DUTY_W   = 7;

    // dark lamp: on at 1.50 x base, off at 1.10 x base
    localparam int DARK_SCALE = 10;
    localparam int DARK_ON    = 15;
    localparam int DARK_OFF   = 11;
    localparam int DARK_W     = 14;

    // hot lamp: on above 1.04 x base, off below 1.02 x base
    localparam int HOT_SCALE = 100;
    localparam int HOT_ON    = 104;
    localparam int HOT_OFF   = 102;
    localparam int HOT_W     = 17;

    // touch: arm at 0.9 x base, release at 0.7 x base
    localparam int TOUCH_SCALE   = 10;
    localparam int TOUCH_ARM     = 9;
    localparam int TOUCH_RELEASE = 7;
    localparam int TOUCH_W       = 14;

    // duty = (light - 50) * 100 / 950, clamped
    localparam int PWM_OFFSET   = 50;
    localparam int PWM_PERCENT  = 100;
    localparam int PWM_SPAN     = 950;
    localparam int PWM_LOW_CUT  = 5;
    localparam int PWM_HIGH_CUT = 95;
    localparam int PWM_PROD_W   = 17;

    // divide by the span as a multiply by a rounded-up reciprocal and a shift
    localparam int PWM_DIV_SHIFT = 27;
    localparam int PWM_RECIP     = ((1 << PWM_DIV_SHIFT) + PWM_SPAN - 1) / PWM_SPAN;
    localparam int PWM_RECIP_W   = 18;
    localparam int PWM_MUL_W     = PWM_PROD_W + PWM_RECIP_W;

    typedef struct packed {
        logic [SAMPLE_W-1:0] light_sample;
        logic [SAMPLE_W-1:0] touch_sample;
        logic [SAMPLE_W-1:0] temp_sample;
    } t_sample;

    typedef struct packed {
        logic [SAMPLE_W-1:0] light;
        logic [SAMPLE_W-1:0] touch;
        logic [SAMPLE_W-1:0] temp;
    } t_avg;

    typedef struct packed {
        logic [DUTY_W-1:0]   pwm_duty;
        logic                dark_lamp;
        logic                hot_lamp;
        logic                motor_reverse;
        logic [SAMPLE_W-1:0] avg_light;
        logic [SAMPLE_W-1:0] avg_touch;
        logic [SAMPLE_W-1:0] avg_temp;
    } t_result;

endpackage

### hdl/sahc_if.sv
// valid/ready channel interfaces for sample items and result items
// depends on sahc_pkg for the payload types

interface sahc_sample_if;
    import sahc_pkg::*;
    logic    valid;
    logic    ready;
    t_sample data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sahc_result_if;
    import sahc_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/sahc_accum.sv
// group accumulator: running sums and sample count, group average out
// depends on sahc_pkg

module sahc_accum #(
    parameter int SAMPLES_PER_GROUP = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  sahc_pkg::t_sample i_sample,
    output logic             o_last,
    output sahc_pkg::t_avg   o_avg
);
    import sahc_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_GROUP);
    localparam int CNT_W = (SAMPLES_PER_GROUP > 1) ? $clog2(SAMPLES_PER_GROUP) : 1;

    // divide by the group size as a multiply by a rounded-up reciprocal and a shift
    localparam int DIV_SHIFT = SUM_W + 3;
    localparam int DIV_RECIP = ((1 << DIV_SHIFT) + SAMPLES_PER_GROUP - 1) / SAMPLES_PER_GROUP;
    localparam int MUL_W     = SUM_W + DIV_SHIFT + 1;

    logic [CNT_W-1:0] r_count, n_count;
    logic [SUM_W-1:0] r_light_sum, r_touch_sum, r_temp_sum;
    logic [SUM_W-1:0] n_light_sum, n_touch_sum, n_temp_sum;
    logic [SUM_W-1:0] light_total, touch_total, temp_total;
    logic [MUL_W-1:0] light_prod, touch_prod, temp_prod;

    assign o_last = (r_count == CNT_W'(SAMPLES_PER_GROUP - 1));

    assign light_total = r_light_sum + SUM_W'(i_sample.light_sample);
    assign touch_total = r_touch_sum + SUM_W'(i_sample.touch_sample);
    assign temp_total  = r_temp_sum + SUM_W'(i_sample.temp_sample);

    assign light_prod = MUL_W'(light_total) * MUL_W'(DIV_RECIP);
    assign touch_prod = MUL_W'(touch_total) * MUL_W'(DIV_RECIP);
    assign temp_prod  = MUL_W'(temp_total) * MUL_W'(DIV_RECIP);

    assign o_avg.light = SAMPLE_W'(light_prod >> DIV_SHIFT);
    assign o_avg.touch = SAMPLE_W'(touch_prod >> DIV_SHIFT);
    assign o_avg.temp  = SAMPLE_W'(temp_prod >> DIV_SHIFT);

    always_comb begin
        n_count     = r_count;
        n_light_sum = r_light_sum;
        n_touch_sum = r_touch_sum;
        n_temp_sum  = r_temp_sum;
        if (i_take) begin
            if (o_last) begin
                n_count     = '0;
                n_light_sum = '0;
                n_touch_sum = '0;
                n_temp_sum  = '0;
            end else begin
                n_count     = r_count + CNT_W'(1);
                n_light_sum = light_total;
                n_touch_sum = touch_total;
                n_temp_sum  = temp_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_light_sum <= '0;
            r_touch_sum <= '0;
            r_temp_sum  <= '0;
        end else begin
            r_count     <= n_count;
            r_light_sum <= n_light_sum;
            r_touch_sum <= n_touch_sum;
            r_temp_sum  <= n_temp_sum;
        end
    end

endmodule

### hdl/sahc_decide.sv
// baseline capture, lamp hysteresis, touch toggle and pwm duty
// depends on sahc_pkg

module sahc_decide (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  sahc_pkg::t_avg    i_avg,
    output logic              o_emit,
    output sahc_pkg::t_result o_result
);
    import sahc_pkg::*;

    logic                r_baseline_taken;
    logic [SAMPLE_W-1:0] r_light_base, r_touch_base, r_temp_base;
    logic                r_dark_on, r_hot_on, r_touch_armed, r_direction;
    logic                n_dark_on, n_hot_on, n_touch_armed, n_direction;

    logic [DARK_W-1:0]     light_scaled, dark_on_lim, dark_off_lim;
    logic [HOT_W-1:0]      temp_scaled, hot_on_lim, hot_off_lim;
    logic [TOUCH_W-1:0]    touch_scaled, arm_lim, release_lim;
    logic [SAMPLE_W-1:0]   light_excess;
    logic [PWM_PROD_W-1:0] duty_num;
    logic [PWM_MUL_W-1:0]  duty_prod;
    logic [PWM_PROD_W-1:0] duty_raw;
    logic [DUTY_W-1:0]     duty;

    assign light_scaled = DARK_W'(i_avg.light) * DARK_W'(DARK_SCALE);
    assign dark_on_lim  = DARK_W'(r_light_base) * DARK_W'(DARK_ON);
    assign dark_off_lim = DARK_W'(r_light_base) * DARK_W'(DARK_OFF);
    assign temp_scaled  = HOT_W'(i_avg.temp) * HOT_W'(HOT_SCALE);
    assign hot_on_lim   = HOT_W'(r_temp_base) * HOT_W'(HOT_ON);
    assign hot_off_lim  = HOT_W'(r_temp_base) * HOT_W'(HOT_OFF);
    assign touch_scaled = TOUCH_W'(i_avg.touch) * TOUCH_W'(TOUCH_SCALE);
    assign arm_lim      = TOUCH_W'(r_touch_base) * TOUCH_W'(TOUCH_ARM);
    assign release_lim  = TOUCH_W'(r_touch_base) * TOUCH_W'(TOUCH_RELEASE);

    // below the offset the duty is negative and clamps to zero
    assign light_excess = (i_avg.light > SAMPLE_W'(PWM_OFFSET))
                        ? i_avg.light - SAMPLE_W'(PWM_OFFSET) : '0;
    assign duty_num  = PWM_PROD_W'(light_excess) * PWM_PROD_W'(PWM_PERCENT);
    assign duty_prod = PWM_MUL_W'(duty_num) * PWM_MUL_W'(PWM_RECIP);
    assign duty_raw  = PWM_PROD_W'(duty_prod >> PWM_DIV_SHIFT);

    always_comb begin
        if (duty_raw <= PWM_PROD_W'(PWM_LOW_CUT)) begin
            duty = '0;
        end else if (duty_raw >= PWM_PROD_W'(PWM_HIGH_CUT)) begin
            duty = DUTY_W'(PWM_PERCENT);
        end else begin
            duty = DUTY_W'(duty_raw);
        end
    end

    always_comb begin
        n_dark_on = r_dark_on;
        if (light_scaled >= dark_on_lim) begin
            n_dark_on = 1'b1;
        end
        if (light_scaled <= dark_off_lim) begin
            n_dark_on = 1'b0;
        end

        n_hot_on = r_hot_on;
        if (temp_scaled > hot_on_lim) begin
            n_hot_on = 1'b1;
        end
        if (temp_scaled < hot_off_lim) begin
            n_hot_on = 1'b0;
        end

        n_touch_armed = r_touch_armed;
        n_direction   = r_direction;
        if (touch_scaled >= arm_lim) begin
            n_touch_armed = 1'b1;
        end
        if (touch_scaled <= release_lim && n_touch_armed) begin
            n_touch_armed = 1'b0;
            n_direction   = !r_direction;
        end
    end

    assign o_emit = i_take && r_baseline_taken;

    assign o_result.pwm_duty      = duty;
    assign o_result.dark_lamp     = n_dark_on;
    assign o_result.hot_lamp      = n_hot_on;
    assign o_result.motor_reverse = n_direction;
    assign o_result.avg_light     = i_avg.light;
    assign o_result.avg_touch     = i_avg.touch;
    assign o_result.avg_temp      = i_avg.temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline_taken <= 1'b0;
            r_light_base     <= '0;
            r_touch_base     <= '0;
            r_temp_base      <= '0;
            r_dark_on        <= 1'b0;
            r_hot_on         <= 1'b0;
            r_touch_armed    <= 1'b0;
            r_direction      <= 1'b0;
        end else if (i_take) begin
            if (!r_baseline_taken) begin
                r_baseline_taken <= 1'b1;
                r_light_base     <= i_avg.light;
                r_touch_base     <= i_avg.touch;
                r_temp_base      <= i_avg.temp;
            end else begin
                r_dark_on     <= n_dark_on;
                r_hot_on      <= n_hot_on;
                r_touch_armed <= n_touch_armed;
                r_direction   <= n_direction;
            end
        end
    end

endmodule

### hdl/sensor_average_hysteresis_control.sv
// Sensor averaging and hysteresis control, top level. Takes one light/touch/temperature
// item per clock and averages SAMPLES_PER_GROUP items per group; the first group sets the
// room baseline, each later group gives one result with pwm duty, dark and hot lamps,
// motor direction and the three averages. Three register stages (input register,
// group-average register, result register) each hand on one item per cycle, so the
// sustained rate is one item per clock; after the last item of its group is accepted,
// a result goes through the group-average and result registers. Items keep flowing while
// a result waits; input ready drops only when a completed group average cannot move on.
// Depends on sahc_pkg, sahc_if, sahc_accum and sahc_decide.

module sensor_average_hysteresis_control #(
    parameter int SAMPLES_PER_GROUP = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sahc_sample_if.sink         i_sample,
    sahc_result_if.source       o_result
);
    import sahc_pkg::*;

    logic    r_in_valid;
    t_sample r_in;
    logic    r_avg_valid;
    t_avg    r_avg;
    logic    r_out_valid;
    t_result r_out;

    logic    out_free, avg_adv, avg_free, in_adv, in_free;
    logic    group_last, emit;
    t_avg    group_avg;
    t_result result;

    assign out_free = !r_out_valid || o_result.ready;
    assign avg_adv  = r_avg_valid && out_free;
    assign avg_free = !r_avg_valid || avg_adv;
    assign in_adv   = r_in_valid && (!group_last || avg_free);
    assign in_free  = !r_in_valid || in_adv;

    assign i_sample.ready = in_free;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    sahc_accum #(
        .SAMPLES_PER_GROUP(SAMPLES_PER_GROUP)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (in_adv),
        .i_sample (r_in),
        .o_last   (group_last),
        .o_avg    (group_avg)
    );

    sahc_decide u_decide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (avg_adv),
        .i_avg    (r_avg),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_avg_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_valid <= i_sample.valid;
            end
            if (avg_free) begin
                r_avg_valid <= in_adv && group_last;
            end
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free) begin
            r_in <= i_sample.data;
        end
        if (avg_free && in_adv && group_last) begin
            r_avg <= group_avg;
        end
        if (emit) begin
            r_out <= result;
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// testbench for sensor_average_hysteresis_control: random and directed sample items,
// a cycle-free predictor of averages, lamps, touch direction and pwm duty, result checker
// depends on sahc_pkg, sahc_if and the sensor_average_hysteresis_control rtl

module testbench;
    import sahc_pkg::*;

    localparam int GROUP_LEN   = 5;
    localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
    localparam int MAX_GAP     = 11;
    localparam int DRAIN_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;

    logic i_clk;
    logic i_rst_n;

    sahc_sample_if smp_ch ();
    sahc_result_if res_ch ();

    sensor_average_hysteresis_control #(
        .SAMPLES_PER_GROUP(GROUP_LEN)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_ch),
        .o_result (res_ch)
    );

    // predictor state
    int acc_count;
    int acc_light;
    int acc_touch;
    int acc_temp;
    bit have_room_base;
    int room_light;
    int room_touch;
    int room_temp;
    bit lamp_dark;
    bit lamp_hot;
    bit touch_latched;
    bit motor_dir;

    t_result expected_results[$];

    bit src_idle;
    bit rx_idle;
    int rx_hold_cycles;

    int items_sent;
    int results_checked;
    int mismatches;
    int reversals;
    int dark_results;
    int hot_results;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic predict_sample(input t_sample s);
        int la;
        int ta;
        int ma;
        int duty;
        t_result want;
        acc_light += s.light_sample;
        acc_touch += s.touch_sample;
        acc_temp  += s.temp_sample;
        if (acc_count + 1 < GROUP_LEN) begin
            acc_count++;
            return;
        end
        la = acc_light / GROUP_LEN;
        ta = acc_touch / GROUP_LEN;
        ma = acc_temp / GROUP_LEN;
        acc_count = 0;
        acc_light = 0;
        acc_touch = 0;
        acc_temp  = 0;
        if (!have_room_base) begin
            room_light = la;
            room_touch = ta;
            room_temp  = ma;
            have_room_base = 1'b1;
            return;
        end
        if (DARK_SCALE * la >= DARK_ON * room_light) lamp_dark = 1'b1;
        if (DARK_SCALE * la <= DARK_OFF * room_light) lamp_dark = 1'b0;
        if (HOT_SCALE * ma > HOT_ON * room_temp) lamp_hot = 1'b1;
        if (HOT_SCALE * ma < HOT_OFF * room_temp) lamp_hot = 1'b0;
        if (TOUCH_SCALE * ta >= TOUCH_ARM * room_touch && !touch_latched) touch_latched = 1'b1;
        if (TOUCH_SCALE * ta <= TOUCH_RELEASE * room_touch && touch_latched) begin
            touch_latched = 1'b0;
            motor_dir = ~motor_dir;
            reversals++;
        end
        duty = ((la - PWM_OFFSET) * PWM_PERCENT) / PWM_SPAN;
        if (duty <= PWM_LOW_CUT) duty = 0;
        else if (duty >= PWM_HIGH_CUT) duty = PWM_PERCENT;
        want.pwm_duty      = duty[DUTY_W-1:0];
        want.dark_lamp     = lamp_dark;
        want.hot_lamp      = lamp_hot;
        want.motor_reverse = motor_dir;
        want.avg_light     = la[SAMPLE_W-1:0];
        want.avg_touch     = ta[SAMPLE_W-1:0];
        want.avg_temp      = ma[SAMPLE_W-1:0];
        dark_results += lamp_dark;
        hot_results  += lamp_hot;
        expected_results.push_back(want);
    endtask

    task automatic report_mismatch(input string what, input t_result want, input t_result got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, what);
            $display("  expected duty %0d dark %0b hot %0b rev %0b avg %0d/%0d/%0d",
                     want.pwm_duty, want.dark_lamp, want.hot_lamp, want.motor_reverse,
                     want.avg_light, want.avg_touch, want.avg_temp);
            $display("  actual   duty %0d dark %0b hot %0b rev %0b avg %0d/%0d/%0d",
                     got.pwm_duty, got.dark_lamp, got.hot_lamp, got.motor_reverse,
                     got.avg_light, got.avg_touch, got.avg_temp);
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        results_checked++;
        if (expected_results.size() == 0) begin
            report_mismatch("result with none expected", '0, got);
            return;
        end
        want = expected_results.pop_front();
        if (want.pwm_duty != got.pwm_duty || want.dark_lamp != got.dark_lamp
                || want.hot_lamp != got.hot_lamp || want.motor_reverse != got.motor_reverse
                || want.avg_light != got.avg_light || want.avg_touch != got.avg_touch
                || want.avg_temp != got.avg_temp) begin
            report_mismatch("result mismatch", want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            check_result(res_ch.data);
        end
    end

    // result receiver with random stalls and an optional long hold
    initial begin
        int gap;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                res_ch.ready <= 1'b0;
                for (int c = 0; c < rx_hold_cycles; c++) @(posedge i_clk);
                rx_hold_cycles = 0;
            end
            gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
        end
    end

    task automatic send_sample(input int l, input int t, input int m);
        int gap;
        t_sample s;
        gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            smp_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s.light_sample = l[SAMPLE_W-1:0];
        s.touch_sample = t[SAMPLE_W-1:0];
        s.temp_sample  = m[SAMPLE_W-1:0];
        smp_ch.data  <= s;
        smp_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!smp_ch.ready) @(posedge i_clk);
        predict_sample(s);
        items_sent++;
    endtask

    // the sender goes idle while waiting for results
    task automatic wait_results_drained();
        int waited;
        smp_ch.valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    function automatic int near_level(input int center, input int spread);
        int v;
        v = int'($urandom_range(0, 2 * spread));
        v = center + v - spread;
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        return v;
    endfunction

    // four items at the level and a fifth a little above, to exercise truncation
    task automatic send_level_group(input int l, input int t, input int m);
        for (int i = 0; i < GROUP_LEN - 1; i++) send_sample(l, t, m);
        send_sample((l <= SAMPLE_MAX - 4) ? l + 4 : l, (t <= SAMPLE_MAX - 4) ? t + 4 : t,
                    (m <= SAMPLE_MAX - 4) ? m + 4 : m);
    endtask

    task automatic test_directed_levels();
        src_idle = 1'b0;
        rx_idle  = 1'b0;
        // room baseline 400 / 500 / 500 from extreme samples
        send_sample(0, 1023, 0);
        send_sample(1023, 0, 1023);
        send_sample(512, 1023, 0);
        send_sample(465, 0, 1023);
        send_sample(0, 454, 454);
        send_level_group(1023, 1023, 1023);
        send_level_group(0, 0, 0);
        // exact set thresholds: dark on, touch arm, hot on
        send_level_group(600, 450, 521);
        // exact clear thresholds: dark off, touch release, hot off
        send_level_group(440, 350, 509);
        wait_results_drained();
    endtask

    task automatic run_random_groups(input int n_groups);
        int lt;
        int tt;
        int mt;
        int spread;
        bit scatter;
        for (int g = 0; g < n_groups; g++) begin
            scatter = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 5))
                0: lt = (DARK_ON * room_light + DARK_SCALE - 1) / DARK_SCALE;
                1: lt = DARK_OFF * room_light / DARK_SCALE;
                2: lt = 107;
                3: lt = 953;
                4: lt = PWM_OFFSET;
                default: lt = $urandom_range(0, SAMPLE_MAX);
            endcase
            case ($urandom_range(0, 2))
                0: tt = (TOUCH_ARM * room_touch + TOUCH_SCALE - 1) / TOUCH_SCALE;
                1: tt = TOUCH_RELEASE * room_touch / TOUCH_SCALE;
                default: tt = $urandom_range(0, SAMPLE_MAX);
            endcase
            case ($urandom_range(0, 2))
                0: mt = HOT_ON * room_temp / HOT_SCALE + 1;
                1: mt = HOT_OFF * room_temp / HOT_SCALE;
                default: mt = $urandom_range(0, SAMPLE_MAX);
            endcase
            spread = $urandom_range(0, 3);
            for (int i = 0; i < GROUP_LEN; i++) begin
                if (scatter) begin
                    send_sample($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                                $urandom_range(0, SAMPLE_MAX));
                end else begin
                    send_sample(near_level(lt, spread), near_level(tt, spread),
                                near_level(mt, spread));
                end
            end
        end
    endtask

    task automatic test_random_full_rate();
        src_idle = 1'b0;
        rx_idle  = 1'b0;
        run_random_groups(70);
    endtask

    task automatic test_random_idling();
        src_idle = 1'b1;
        rx_idle  = 1'b1;
        run_random_groups(60);
        src_idle = 1'b0;
        run_random_groups(30);
        src_idle = 1'b1;
        rx_idle  = 1'b0;
        run_random_groups(30);
    endtask

    task automatic test_output_backpressure();
        wait_results_drained();
        src_idle = 1'b0;
        rx_idle  = 1'b0;
        rx_hold_cycles = 300;
        run_random_groups(14);
        wait_results_drained();
    endtask

    task automatic test_sender_pause();
        src_idle = 1'b1;
        rx_idle  = 1'b1;
        run_random_groups(50);
        wait_results_drained();
        run_random_groups(52);
    endtask

    initial begin
        smp_ch.valid <= 1'b0;
        smp_ch.data  <= '0;
        i_rst_n      <= 1'b0;
        acc_count = 0;
        acc_light = 0;
        acc_touch = 0;
        acc_temp  = 0;
        have_room_base = 1'b0;
        room_light = 0;
        room_touch = 0;
        room_temp  = 0;
        lamp_dark = 1'b0;
        lamp_hot  = 1'b0;
        touch_latched = 1'b0;
        motor_dir = 1'b0;
        src_idle = 1'b0;
        rx_idle  = 1'b0;
        rx_hold_cycles = 0;
        items_sent = 0;
        results_checked = 0;
        mismatches = 0;
        reversals = 0;
        dark_results = 0;
        hot_results = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_levels();
        test_random_full_rate();
        test_random_idling();
        test_output_backpressure();
        test_sender_pause();

        wait_results_drained();
        repeat (20) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0d expected results never arrived", expected_results.size());
            mismatches += expected_results.size();
        end
        $display("sent %0d sample items, checked %0d results with %0d mismatches",
                 items_sent, results_checked, mismatches);
        $display("seen %0d motor reversals, %0d dark-lamp and %0d hot-lamp results",
                 reversals, dark_results, hot_results);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
hdl/sahc_pkg.sv
hdl/sahc_if.sv
hdl/sahc_accum.sv
hdl/sahc_decide.sv
hdl/sensor_average_hysteresis_control.sv
tb/testbench.sv
